### src/vdit_pkg.sv
// Package for the vertex welding table: sizes, hash constants, item and state types, float helpers.
// Used by every module under src except vdit_ram; no dependencies.
`default_nettype none
package vdit_pkg;

    localparam int CAPACITY     = 65536;
    localparam int HASH_BUCKETS = 1024;
    localparam int IDX_W        = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W        = IDX_W + 1;
    localparam int BKT_W        = (HASH_BUCKETS > 1) ? $clog2(HASH_BUCKETS) : 1;
    localparam int OUT_W        = 16;
    localparam int KEY_W        = 96;

    localparam logic [31:0]      HASH_MUL_Y = 32'h85EB_CA6B;
    localparam logic [31:0]      HASH_MUL_Z = 32'hC2B2_AE35;
    localparam logic [31:0]      HASH_MUL_H = 32'h9E37_79B1;
    localparam logic [BKT_W-1:0] BKT_MASK   = BKT_W'(HASH_BUCKETS - 1);
    localparam logic [BKT_W-1:0] BKT_LAST   = BKT_W'(HASH_BUCKETS - 1);
    localparam logic [CNT_W-1:0] CNT_FULL   = CNT_W'(CAPACITY);

    typedef struct packed {
        logic             start;
        logic             nan;
        logic [BKT_W-1:0] bucket;
        logic [31:0]      x;
        logic [31:0]      y;
        logic [31:0]      z;
    } t_job;

    typedef struct packed {
        logic [OUT_W-1:0] index;
        logic             is_new;
        logic             overflow;
    } t_result;

    typedef enum logic [3:0] {
        S_CLR,
        S_IDLE,
        S_HEAD,
        S_HEADD,
        S_KEY,
        S_KEYD,
        S_NEW,
        S_OUT
    } t_bstate;

    function automatic logic [31:0] norm_zero(input logic [31:0] b);
        return (b[30:0] == 31'd0) ? 32'd0 : b;
    endfunction

    function automatic logic is_nan(input logic [31:0] b);
        return (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    endfunction

endpackage
`default_nettype wire

### src/vertex_dedup_index_table.sv
// Vertex welding table, top level: front end, item queue, table engine.
// The table engine handles one item at a time; the front end and queue can hold further items.
// Each chain entry walked adds a registered read of the key memory (S_KEY, S_KEYD).
// start_mesh adds a bucket-head sweep that clears the table before that item is looked up.
// After reset the same sweep runs; no item is taken until done.
`default_nettype none
module vertex_dedup_index_table
    import vdit_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic        i_start_mesh,
    input  wire logic [31:0] i_x_bits,
    input  wire logic [31:0] i_y_bits,
    input  wire logic [31:0] i_z_bits,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [15:0]      o_vertex_index,
    output logic             o_is_new,
    output logic             o_overflow
);
    t_job    f_job, q_job;
    t_result res;
    logic    f_valid, q_ready, q_valid, q_pop, init_busy;

    vdit_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_start_mesh,
        .i_x_bits, .i_y_bits, .i_z_bits, .i_hold(init_busy),
        .o_job_valid(f_valid), .i_job_ready(q_ready), .o_job(f_job)
    );
    vdit_queue u_queue (
        .i_clk, .i_rst_n, .i_push(f_valid), .o_ready(q_ready), .i_job(f_job),
        .o_valid(q_valid), .i_pop(q_pop), .o_job(q_job)
    );
    vdit_back u_back (
        .i_clk, .i_rst_n, .i_job_valid(q_valid), .o_job_pop(q_pop), .i_job(q_job),
        .o_init_busy(init_busy), .o_valid, .i_ready, .o_res(res)
    );

    assign o_vertex_index = res.index;
    assign o_is_new       = res.is_new;
    assign o_overflow     = res.overflow;
endmodule
`default_nettype wire

### src/vdit_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module vdit_ram #(
    parameter int W = 32,
    parameter int D = 1024
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_we,
    input  wire logic [((D > 1) ? $clog2(D) : 1)-1:0] i_waddr,
    input  wire logic [W-1:0]                       i_wdata,
    input  wire logic [((D > 1) ? $clog2(D) : 1)-1:0] i_raddr,
    output logic      [W-1:0]                       o_rdata
);
    logic [W-1:0] r_mem [D];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

### src/vdit_front.sv
// Front end: accepts vertex items, folds signed zero, flags NaN, hashes to a bucket.
// Depends on vdit_pkg.
`default_nettype none
module vdit_front
    import vdit_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic        i_start_mesh,
    input  wire logic [31:0] i_x_bits,
    input  wire logic [31:0] i_y_bits,
    input  wire logic [31:0] i_z_bits,
    input  wire logic        i_hold,
    output logic             o_job_valid,
    input  wire logic        i_job_ready,
    output t_job             o_job
);
    logic        r_va, r_vb;
    logic        r_sa, r_na, r_sb, r_nb;
    logic [31:0] r_xa, r_ya, r_za, r_pya, r_pza;
    logic [31:0] r_xb, r_yb, r_zb, r_phb;
    logic [31:0] n_xa, n_ya, n_za, h1, h2;
    logic        rdy_a, rdy_b, take;

    assign rdy_b   = !r_vb || i_job_ready;
    assign rdy_a   = !r_va || rdy_b;
    assign o_ready = rdy_a && !i_hold;
    assign take    = i_valid && o_ready;

    assign n_xa = norm_zero(i_x_bits);
    assign n_ya = norm_zero(i_y_bits);
    assign n_za = norm_zero(i_z_bits);

    always_comb begin
        h1 = r_xa ^ r_pya ^ r_pza;
        h1 = h1 ^ (h1 >> 16);
        h2 = r_phb ^ (r_phb >> 13);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else begin
            if (rdy_a) r_va <= take;
            if (rdy_b) r_vb <= r_va;
        end
        if (take) begin
            r_xa  <= n_xa;
            r_ya  <= n_ya;
            r_za  <= n_za;
            r_sa  <= i_start_mesh;
            r_na  <= is_nan(n_xa) || is_nan(n_ya) || is_nan(n_za);
            r_pya <= n_ya * HASH_MUL_Y;
            r_pza <= n_za * HASH_MUL_Z;
        end
        if (rdy_b && r_va) begin
            r_xb  <= r_xa;
            r_yb  <= r_ya;
            r_zb  <= r_za;
            r_sb  <= r_sa;
            r_nb  <= r_na;
            r_phb <= h1 * HASH_MUL_H;
        end
    end

    assign o_job_valid  = r_vb;
    assign o_job.start  = r_sb;
    assign o_job.nan    = r_nb;
    assign o_job.bucket = BKT_W'(h2) & BKT_MASK;
    assign o_job.x      = r_xb;
    assign o_job.y      = r_yb;
    assign o_job.z      = r_zb;
endmodule
`default_nettype wire

### src/vdit_queue.sv
// Two-entry item queue between front end and table engine.
// Depends on vdit_pkg.
`default_nettype none
module vdit_queue
    import vdit_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    output logic      o_ready,
    input  t_job      i_job,
    output logic      o_valid,
    input  wire logic i_pop,
    output t_job      o_job
);
    t_job       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       do_push, do_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) r_wp <= !r_wp;
            if (do_pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, do_push} - {1'b0, do_pop};
        end
        if (do_push) r_mem[r_wp] <= i_job;
    end
endmodule
`default_nettype wire

### src/vdit_back.sv
// Table engine: bucket probe, chain walk, insert, clearing sweep, result register.
// Depends on vdit_pkg and vdit_ram.
`default_nettype none
module vdit_back
    import vdit_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_job_valid,
    output logic      o_job_pop,
    input  t_job      i_job,
    output logic      o_init_busy,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_result   o_res
);
    t_bstate          r_state, n_state;
    t_job             r_job;
    t_result          r_res, r_out;
    logic             r_ovalid, r_init;
    logic [BKT_W-1:0] r_clr;
    logic [CNT_W-1:0] r_count, r_link, r_head, link_m1;

    logic             head_we, key_we;
    logic [BKT_W-1:0] head_waddr, head_raddr;
    logic [CNT_W-1:0] head_wdata, head_rdata, next_rdata, next_wdata;
    logic [KEY_W-1:0] key_rdata;
    logic             key_hit, chain_ok, full, out_load;

    assign link_m1  = r_link - CNT_W'(1);
    assign key_hit  = key_rdata == {r_job.x, r_job.y, r_job.z};
    assign chain_ok = !r_job.nan && head_rdata != '0 && head_rdata <= r_count;
    assign full     = r_count == CNT_FULL;
    assign out_load = !r_ovalid || i_ready;

    vdit_ram #(.W(CNT_W), .D(HASH_BUCKETS)) u_heads (
        .i_clk, .i_we(head_we), .i_waddr(head_waddr), .i_wdata(head_wdata),
        .i_raddr(head_raddr), .o_rdata(head_rdata)
    );
    vdit_ram #(.W(KEY_W), .D(CAPACITY)) u_keys (
        .i_clk, .i_we(key_we), .i_waddr(r_count[IDX_W-1:0]),
        .i_wdata({r_job.x, r_job.y, r_job.z}),
        .i_raddr(link_m1[IDX_W-1:0]), .o_rdata(key_rdata)
    );
    vdit_ram #(.W(CNT_W), .D(CAPACITY)) u_next (
        .i_clk, .i_we(key_we), .i_waddr(r_count[IDX_W-1:0]), .i_wdata(next_wdata),
        .i_raddr(link_m1[IDX_W-1:0]), .o_rdata(next_rdata)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLR:   if (r_clr == BKT_LAST) n_state = r_init ? S_IDLE : S_HEAD;
            S_IDLE:  if (i_job_valid) n_state = i_job.start ? S_CLR : S_HEAD;
            S_HEAD:  n_state = S_HEADD;
            S_HEADD: n_state = chain_ok ? S_KEY : S_NEW;
            S_KEY:   n_state = S_KEYD;
            S_KEYD: begin
                if (key_hit)                n_state = S_OUT;
                else if (next_rdata == '0)  n_state = S_NEW;
                else                        n_state = S_KEY;
            end
            S_NEW:   n_state = S_OUT;
            S_OUT:   if (out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_job_pop  = 1'b0;
        head_we    = 1'b0;
        key_we     = 1'b0;
        head_waddr = r_job.bucket;
        head_wdata = r_count + CNT_W'(1);
        head_raddr = r_job.bucket;
        next_wdata = r_job.nan ? '0 : r_head;
        unique case (r_state)
            S_CLR: begin
                head_we    = 1'b1;
                head_waddr = r_clr;
                head_wdata = '0;
            end
            S_IDLE: o_job_pop = i_job_valid;
            S_NEW: begin
                key_we  = !full;
                head_we = !full && !r_job.nan;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_init   <= 1'b1;
            r_clr    <= '0;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLR) begin
                if (r_clr == BKT_LAST) begin
                    r_init  <= 1'b0;
                    r_count <= '0;
                    r_clr   <= '0;
                end else begin
                    r_clr <= r_clr + BKT_W'(1);
                end
            end
            if (r_state == S_NEW && !full) r_count <= r_count + CNT_W'(1);
            if (r_state == S_OUT && out_load) r_ovalid <= 1'b1;
            else if (i_ready) r_ovalid <= 1'b0;
        end
        if (r_state == S_IDLE && i_job_valid) r_job <= i_job;
        if (r_state == S_HEADD) begin
            r_head <= head_rdata;
            r_link <= head_rdata;
        end
        if (r_state == S_KEYD) begin
            r_link          <= next_rdata;
            r_res.index     <= OUT_W'(link_m1);
            r_res.is_new    <= 1'b0;
            r_res.overflow  <= 1'b0;
        end
        if (r_state == S_NEW) begin
            r_res.index    <= full ? '0 : OUT_W'(r_count);
            r_res.is_new   <= !full;
            r_res.overflow <= full;
        end
        if (r_state == S_OUT && out_load) r_out <= r_res;
    end

    assign o_init_busy = r_init;
    assign o_valid     = r_ovalid;
    assign o_res       = r_out;
endmodule
`default_nettype wire
